FILE: hw/rtl/pbq_pkg.sv
`timescale 1ns / 1ps

package pbq_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_ACCELERATION = 2'd0,
        REG_GRAVITY      = 2'd1,
        REG_BASE_SIZE    = 2'd2,
        REG_LIFE_SPAN    = 2'd3
    } reg_index_t;

    localparam logic [15:0] ACCEL_RESET     = 16'd0;
    localparam logic [15:0] GRAVITY_RESET   = 16'd0;
    localparam logic [15:0] BASE_SIZE_RESET = 16'd256;
    localparam logic [15:0] LIFE_SPAN_RESET = 16'd1000;

    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = 5;
    localparam int NUM_W        = 50;
    localparam int QUO_W        = 29;
    localparam int ALPHA_W      = 16;

    // Position: n / 2000000 = (n >> 7) / 15625.
    localparam logic [10:0] POS_VEL_SCALE = 11'd2000;
    localparam int          POS_SHIFT     = 7;
    localparam int          POS_RW        = 14;
    localparam logic [POS_RW-1:0] POS_DIVISOR = 14'd15625;
    localparam logic [NUM_W-1:0]  POS_ROUND   = 50'd1000000;

    // Half size: n / 512000 = (n >> 12) / 125.
    localparam logic [17:0] HALF_BASE_SCALE = 18'd256000;
    localparam int          HALF_SHIFT      = 12;
    localparam int          HALF_RW         = 7;
    localparam logic [HALF_RW-1:0] HALF_DIVISOR = 7'd125;
    localparam logic [NUM_W-1:0]   HALF_ROUND   = 50'd256000;

    localparam logic [15:0] Q8_ONE = 16'd256;

    typedef struct packed {
        logic [9:0]         particle_index;
        logic [15:0]        age_ms;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] size_factor;
    } particle_t;

    typedef struct packed {
        logic [9:0]         index_out;
        logic signed [31:0] left_x;
        logic signed [31:0] right_x;
        logic signed [31:0] bottom_y;
        logic signed [31:0] top_y;
        logic [15:0]        alpha;
        logic               expired;
    } quad_t;

    typedef struct packed {
        logic signed [15:0] acceleration;
        logic signed [15:0] gravity;
        logic [15:0]        base_size;
        logic [15:0]        life_span_ms;
        logic [15:0]        life_div;
    } cfg_t;

    typedef struct packed {
        logic [9:0] index;
        logic       x_neg;
        logic       y_neg;
        logic       h_neg;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [POS_RW-1:0]   x_rem;
        logic [QUO_W-1:0]    x_quo;
        logic [POS_RW-1:0]   y_rem;
        logic [QUO_W-1:0]    y_quo;
        logic [HALF_RW-1:0]  h_rem;
        logic [QUO_W-1:0]    h_quo;
        logic [ALPHA_W-1:0]  a_rem;
        logic [ALPHA_W-1:0]  a_quo;
    } front_t;

endpackage

FILE: hw/rtl/pbq_stream_if.sv
`timescale 1ns / 1ps

interface pbq_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

FILE: hw/rtl/particle_ballistic_quad_update.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; four arithmetic stages, a five-stage
// restoring divider chain and the output register set the latency.
// A stalled output holds the whole pipeline in place.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the
// register reset values; payload registers are not reset.

module particle_ballistic_quad_update (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbq_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbq_pkg::DATA_W-1:0]  pwdata,
    output logic [pbq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    pbq_stream_if.sink                  particle,
    pbq_stream_if.source                quad
);

    localparam int PIPE = pbq_pkg::FRONT_STAGES + pbq_pkg::DIV_STAGES;

    pbq_pkg::cfg_t   cfg;
    pbq_pkg::front_t front;
    pbq_pkg::side_t  side_reg [pbq_pkg::DIV_STAGES];
    pbq_pkg::side_t  side;
    pbq_pkg::quad_t  quad_reg, quad_next;

    logic                         vld_reg [PIPE];
    logic                         quad_valid_reg;
    logic                         en;
    logic [pbq_pkg::QUO_W-1:0]    x_quo, y_quo, h_quo;
    logic [pbq_pkg::ALPHA_W-1:0]  a_quo;
    logic signed [31:0]           x_val, y_val, h_val;

    assign en             = !quad_valid_reg || quad.ready;
    assign particle.ready = en;

    pbq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbq_front u_front (
        .clk    (clk),
        .en     (en),
        .item   (particle.data),
        .cfg    (cfg),
        .result (front)
    );

    pbq_div_pipe #(
        .QUO_W  (pbq_pkg::QUO_W),
        .REM_W  (pbq_pkg::POS_RW),
        .STAGES (pbq_pkg::DIV_STAGES)
    ) u_div_x (
        .clk     (clk),
        .en      (en),
        .divisor (pbq_pkg::POS_DIVISOR),
        .rem_in  (front.x_rem),
        .quo_in  (front.x_quo),
        .quo_out (x_quo)
    );

    pbq_div_pipe #(
        .QUO_W  (pbq_pkg::QUO_W),
        .REM_W  (pbq_pkg::POS_RW),
        .STAGES (pbq_pkg::DIV_STAGES)
    ) u_div_y (
        .clk     (clk),
        .en      (en),
        .divisor (pbq_pkg::POS_DIVISOR),
        .rem_in  (front.y_rem),
        .quo_in  (front.y_quo),
        .quo_out (y_quo)
    );

    pbq_div_pipe #(
        .QUO_W  (pbq_pkg::QUO_W),
        .REM_W  (pbq_pkg::HALF_RW),
        .STAGES (pbq_pkg::DIV_STAGES)
    ) u_div_h (
        .clk     (clk),
        .en      (en),
        .divisor (pbq_pkg::HALF_DIVISOR),
        .rem_in  (front.h_rem),
        .quo_in  (front.h_quo),
        .quo_out (h_quo)
    );

    pbq_div_pipe #(
        .QUO_W  (pbq_pkg::ALPHA_W),
        .REM_W  (pbq_pkg::ALPHA_W),
        .STAGES (pbq_pkg::DIV_STAGES)
    ) u_div_alpha (
        .clk     (clk),
        .en      (en),
        .divisor (cfg.life_div),
        .rem_in  (front.a_rem),
        .quo_in  (front.a_quo),
        .quo_out (a_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            quad_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= particle.valid;
            for (int i = 1; i < PIPE; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            quad_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= front.side;
            for (int i = 1; i < pbq_pkg::DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            quad_reg <= quad_next;
        end
    end

    assign side = side_reg[pbq_pkg::DIV_STAGES-1];

    // The rounded values stay well inside the 32-bit range, so the bounds
    // are exact sums.
    always_comb
    begin
        x_val = side.x_neg ? -$signed(32'(x_quo)) : $signed(32'(x_quo));
        y_val = side.y_neg ? -$signed(32'(y_quo)) : $signed(32'(y_quo));
        h_val = side.h_neg ? -$signed(32'(h_quo)) : $signed(32'(h_quo));

        quad_next.index_out = side.index;
        quad_next.left_x    = x_val - h_val;
        quad_next.right_x   = x_val + h_val;
        quad_next.bottom_y  = y_val - h_val;
        quad_next.top_y     = y_val + h_val;
        quad_next.alpha     = a_quo;
        quad_next.expired   = (a_quo == '0);
    end

    assign quad.valid = quad_valid_reg;
    assign quad.data  = quad_reg;

endmodule

FILE: hw/rtl/pbq_regs.sv
`timescale 1ns / 1ps

module pbq_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbq_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbq_pkg::DATA_W-1:0]  pwdata,
    output logic [pbq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pbq_pkg::cfg_t               cfg
);

    logic [15:0] accel_reg;
    logic [15:0] gravity_reg;
    logic [15:0] base_size_reg;
    logic [15:0] life_span_reg;
    pbq_pkg::reg_index_t index;
    logic        wr_en;

    assign index  = pbq_pkg::reg_index_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= pbq_pkg::ACCEL_RESET;
            gravity_reg   <= pbq_pkg::GRAVITY_RESET;
            base_size_reg <= pbq_pkg::BASE_SIZE_RESET;
            life_span_reg <= pbq_pkg::LIFE_SPAN_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                pbq_pkg::REG_ACCELERATION: accel_reg     <= pwdata[15:0];
                pbq_pkg::REG_GRAVITY:      gravity_reg   <= pwdata[15:0];
                pbq_pkg::REG_BASE_SIZE:    base_size_reg <= pwdata[15:0];
                pbq_pkg::REG_LIFE_SPAN:    life_span_reg <= pwdata[15:0];
                default:                   accel_reg     <= accel_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            pbq_pkg::REG_ACCELERATION: prdata = {16'd0, accel_reg};
            pbq_pkg::REG_GRAVITY:      prdata = {16'd0, gravity_reg};
            pbq_pkg::REG_BASE_SIZE:    prdata = {16'd0, base_size_reg};
            pbq_pkg::REG_LIFE_SPAN:    prdata = {16'd0, life_span_reg};
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.acceleration = $signed(accel_reg);
        cfg.gravity      = $signed(gravity_reg);
        cfg.base_size    = base_size_reg;
        cfg.life_span_ms = life_span_reg;
        // A zero lifespan divides as one.
        cfg.life_div     = (life_span_reg == 16'd0) ? 16'd1 : life_span_reg;
    end

endmodule

FILE: hw/rtl/pbq_front.sv
`timescale 1ns / 1ps

module pbq_front (
    input  logic                clk,
    input  logic                en,
    input  pbq_pkg::particle_t  item,
    input  pbq_pkg::cfg_t       cfg,
    output pbq_pkg::front_t     result
);

    localparam int NW = pbq_pkg::NUM_W;

    // Stage 1: products of the input fields.
    logic signed [32:0] s1_vx_age_reg, s1_vx_age_next;
    logic signed [32:0] s1_vy_age_reg, s1_vy_age_next;
    logic [31:0]        s1_age_sq_reg, s1_age_sq_next;
    logic signed [33:0] s1_base_d_reg, s1_base_d_next;
    logic [33:0]        s1_base_k_reg, s1_base_k_next;
    logic [31:0]        s1_num_reg, s1_num_next;
    logic [15:0]        s1_age_reg;
    logic [9:0]         s1_index_reg;
    logic signed [16:0] dsize;
    logic [15:0]        life_left;

    // Stage 2: second products.
    logic signed [44:0] s2_px_reg, s2_px_next;
    logic signed [44:0] s2_py_reg, s2_py_next;
    logic signed [48:0] s2_ax_reg, s2_ax_next;
    logic signed [49:0] s2_ay_reg, s2_ay_next;
    logic signed [49:0] s2_bh_reg, s2_bh_next;
    logic [33:0]        s2_base_k_reg;
    logic [31:0]        s2_num_reg;
    logic [9:0]         s2_index_reg;
    logic signed [16:0] accel_y;

    // Stage 3: numerators.
    logic signed [NW-1:0] s3_nx_reg, s3_nx_next;
    logic signed [NW-1:0] s3_ny_reg, s3_ny_next;
    logic signed [NW-1:0] s3_nh_reg, s3_nh_next;
    logic [31:0]          s3_num_reg;
    logic [9:0]           s3_index_reg;

    // Stage 4: rounded magnitudes split into divider operands.
    pbq_pkg::front_t s4_reg, s4_next;
    logic [NW-1:0]   mag_x, mag_y, mag_h;

    assign dsize     = 17'(item.size_factor) - $signed({1'b0, pbq_pkg::Q8_ONE});
    assign life_left = cfg.life_div - item.age_ms;

    always_comb
    begin
        s1_vx_age_next = item.vel_x * $signed({1'b0, item.age_ms});
        s1_vy_age_next = item.vel_y * $signed({1'b0, item.age_ms});
        s1_age_sq_next = item.age_ms * item.age_ms;
        s1_base_d_next = $signed({1'b0, cfg.base_size}) * dsize;
        s1_base_k_next = cfg.base_size * pbq_pkg::HALF_BASE_SCALE;
        if (item.age_ms >= cfg.life_div)
        begin
            s1_num_next = '0;
        end
        else
        begin
            s1_num_next = {life_left, 16'd0} - {16'd0, life_left};
        end
    end

    assign accel_y = 17'(cfg.acceleration) - 17'(cfg.gravity);

    always_comb
    begin
        s2_px_next = s1_vx_age_reg * $signed({1'b0, pbq_pkg::POS_VEL_SCALE});
        s2_py_next = s1_vy_age_reg * $signed({1'b0, pbq_pkg::POS_VEL_SCALE});
        s2_ax_next = cfg.acceleration * $signed({1'b0, s1_age_sq_reg});
        s2_ay_next = accel_y * $signed({1'b0, s1_age_sq_reg});
        s2_bh_next = s1_base_d_reg * $signed({1'b0, s1_age_reg});
    end

    always_comb
    begin
        s3_nx_next = NW'(s2_px_reg) + NW'(s2_ax_reg);
        s3_ny_next = NW'(s2_py_reg) + NW'(s2_ay_reg);
        s3_nh_next = NW'(s2_bh_reg) + $signed(NW'(s2_base_k_reg));
    end

    // Rounding to nearest with ties away from zero works on the magnitude.
    always_comb
    begin
        mag_x = s3_nx_reg[NW-1] ? (pbq_pkg::POS_ROUND - $unsigned(s3_nx_reg))
                                : ($unsigned(s3_nx_reg) + pbq_pkg::POS_ROUND);
        mag_y = s3_ny_reg[NW-1] ? (pbq_pkg::POS_ROUND - $unsigned(s3_ny_reg))
                                : ($unsigned(s3_ny_reg) + pbq_pkg::POS_ROUND);
        mag_h = s3_nh_reg[NW-1] ? (pbq_pkg::HALF_ROUND - $unsigned(s3_nh_reg))
                                : ($unsigned(s3_nh_reg) + pbq_pkg::HALF_ROUND);

        s4_next.side.index = s3_index_reg;
        s4_next.side.x_neg = s3_nx_reg[NW-1];
        s4_next.side.y_neg = s3_ny_reg[NW-1];
        s4_next.side.h_neg = s3_nh_reg[NW-1];
        s4_next.x_rem = pbq_pkg::POS_RW'(mag_x >> (pbq_pkg::POS_SHIFT + pbq_pkg::QUO_W));
        s4_next.x_quo = mag_x[pbq_pkg::POS_SHIFT +: pbq_pkg::QUO_W];
        s4_next.y_rem = pbq_pkg::POS_RW'(mag_y >> (pbq_pkg::POS_SHIFT + pbq_pkg::QUO_W));
        s4_next.y_quo = mag_y[pbq_pkg::POS_SHIFT +: pbq_pkg::QUO_W];
        s4_next.h_rem = pbq_pkg::HALF_RW'(mag_h >> (pbq_pkg::HALF_SHIFT + pbq_pkg::QUO_W));
        s4_next.h_quo = mag_h[pbq_pkg::HALF_SHIFT +: pbq_pkg::QUO_W];
        s4_next.a_rem = s3_num_reg[31:16];
        s4_next.a_quo = s3_num_reg[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_vx_age_reg <= s1_vx_age_next;
            s1_vy_age_reg <= s1_vy_age_next;
            s1_age_sq_reg <= s1_age_sq_next;
            s1_base_d_reg <= s1_base_d_next;
            s1_base_k_reg <= s1_base_k_next;
            s1_num_reg    <= s1_num_next;
            s1_age_reg    <= item.age_ms;
            s1_index_reg  <= item.particle_index;

            s2_px_reg     <= s2_px_next;
            s2_py_reg     <= s2_py_next;
            s2_ax_reg     <= s2_ax_next;
            s2_ay_reg     <= s2_ay_next;
            s2_bh_reg     <= s2_bh_next;
            s2_base_k_reg <= s1_base_k_reg;
            s2_num_reg    <= s1_num_reg;
            s2_index_reg  <= s1_index_reg;

            s3_nx_reg     <= s3_nx_next;
            s3_ny_reg     <= s3_ny_next;
            s3_nh_reg     <= s3_nh_next;
            s3_num_reg    <= s2_num_reg;
            s3_index_reg  <= s2_index_reg;

            s4_reg        <= s4_next;
        end
    end

    assign result = s4_reg;

endmodule

FILE: hw/rtl/pbq_div_pipe.sv
`timescale 1ns / 1ps

module pbq_div_pipe #(
    parameter int QUO_W  = 29,
    parameter int REM_W  = 14,
    parameter int STAGES = 5
) (
    input  logic             clk,
    input  logic             en,
    input  logic [REM_W-1:0] divisor,
    input  logic [REM_W-1:0] rem_in,
    input  logic [QUO_W-1:0] quo_in,
    output logic [QUO_W-1:0] quo_out
);

    localparam int SPS = (QUO_W + STAGES - 1) / STAGES;

    logic [REM_W-1:0] rem_reg  [STAGES];
    logic [QUO_W-1:0] quo_reg  [STAGES];
    logic [REM_W-1:0] rem_next [STAGES];
    logic [QUO_W-1:0] quo_next [STAGES];

    // Restoring division: the dividend bits shift out of the top of the
    // quotient word while quotient bits shift in at the bottom.
    always_comb
    begin
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] r;
        logic [QUO_W-1:0] q;
        trial = '0;
        r     = '0;
        q     = '0;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                r = rem_in;
                q = quo_in;
            end
            else
            begin
                r = rem_reg[s-1];
                q = quo_reg[s-1];
            end
            for (int k = 0; k < SPS; k++)
            begin
                if (s * SPS + k < QUO_W)
                begin
                    trial = {r, q[QUO_W-1]};
                    if (trial >= {1'b0, divisor})
                    begin
                        trial = trial - {1'b0, divisor};
                        q     = {q[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q     = {q[QUO_W-2:0], 1'b0};
                    end
                    r = trial[REM_W-1:0];
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo_out = quo_reg[STAGES-1];

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import pbq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LATENCY       = 10;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int MS_PER_S      = 1000;
    localparam int Q8_UNIT       = 256;
    localparam int ALPHA_FULL    = 65535;

    class quad_checker;
        logic [15:0] accel_q88   = ACCEL_RESET;
        logic [15:0] gravity_q88 = GRAVITY_RESET;
        logic [15:0] base_q88    = BASE_SIZE_RESET;
        logic [15:0] life_ms     = LIFE_SPAN_RESET;
        quad_t       pending_quads[$];
        int          mismatches;
        int          checked;

        function void set_register(reg_index_t r, logic [15:0] v);
            case (r)
                REG_ACCELERATION: accel_q88   = v;
                REG_GRAVITY:      gravity_q88 = v;
                REG_BASE_SIZE:    base_q88    = v;
                REG_LIFE_SPAN:    life_ms     = v;
                default:          ;
            endcase
        endfunction

        // Round to nearest with ties away from zero; d is positive.
        static function longint round_div(longint n, longint d);
            if (n >= 0)
                return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        static function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function quad_t predict_quad(particle_t p);
            longint age, vx, vy, delta, a, ay, base, life, x, y, half, alpha;
            quad_t  q;
            age   = longint'(p.age_ms);
            vx    = longint'($signed(p.vel_x));
            vy    = longint'($signed(p.vel_y));
            delta = longint'($signed(p.size_factor));
            a     = longint'($signed(accel_q88));
            ay    = a - longint'($signed(gravity_q88));
            base  = longint'(base_q88);
            if (life_ms == 16'd0)
                life = 1;
            else
                life = longint'(life_ms);
            x = round_div(vx * age * 2 * MS_PER_S + a * age * age,
                          2 * MS_PER_S * MS_PER_S);
            y = round_div(vy * age * 2 * MS_PER_S + ay * age * age,
                          2 * MS_PER_S * MS_PER_S);
            half = round_div(base * Q8_UNIT * MS_PER_S + base * (delta - Q8_UNIT) * age,
                             2 * Q8_UNIT * MS_PER_S);
            if (age >= life)
                alpha = 0;
            else
                alpha = (ALPHA_FULL * (life - age)) / life;
            q.index_out = p.particle_index;
            q.left_x    = clamp32(x - half);
            q.right_x   = clamp32(x + half);
            q.bottom_y  = clamp32(y - half);
            q.top_y     = clamp32(y + half);
            q.alpha     = alpha[15:0];
            q.expired   = (alpha == 0);
            return q;
        endfunction

        function void note_particle(particle_t p);
            pending_quads.insert(pending_quads.size(), predict_quad(p));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_quad(quad_t got);
            quad_t want;
            if (pending_quads.size() == 0)
            begin
                $error("quad word for particle %0d arrived with none outstanding",
                       got.index_out);
                mismatches++;
                return;
            end
            want = pending_quads.pop_front();
            checked++;
            if ($isunknown(got))
            begin
                $error("quad word: expected known bits, got %h", got);
                mismatches++;
            end
            compare_field("index_out", want.index_out, got.index_out);
            compare_field("left_x", want.left_x, got.left_x);
            compare_field("right_x", want.right_x, got.right_x);
            compare_field("bottom_y", want.bottom_y, got.bottom_y);
            compare_field("top_y", want.top_y, got.top_y);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("expired", want.expired, got.expired);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pbq_stream_if #(.payload_t(particle_t)) particle_if ();
    pbq_stream_if #(.payload_t(quad_t))     quad_if ();

    quad_checker sb = new;
    bit          hold_request;
    int          holds_done;
    int          input_stalls;
    int          settings;
    int          cycles;
    int          burst_left;

    particle_ballistic_quad_update DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .particle (particle_if),
        .quad     (quad_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic particle_t particle_word(int idx, int age, int vx, int vy, int sf);
        particle_t p;
        p.particle_index = idx[9:0];
        p.age_ms         = age[15:0];
        p.vel_x          = vx[15:0];
        p.vel_y          = vy[15:0];
        p.size_factor    = sf[15:0];
        return p;
    endfunction

    task automatic reg_write(input reg_index_t r, input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        sb.set_register(r, v);
    endtask

    task automatic set_config(input logic [15:0] accel, input logic [15:0] grav,
                              input logic [15:0] base, input logic [15:0] life);
        reg_write(REG_ACCELERATION, accel);
        reg_write(REG_GRAVITY, grav);
        reg_write(REG_BASE_SIZE, base);
        reg_write(REG_LIFE_SPAN, life);
        settings++;
    endtask

    task automatic offer_particle(input particle_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                particle_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        particle_if.valid <= 1'b1;
        particle_if.data  <= p;
        do @(posedge clk); while (!particle_if.ready);
    endtask

    task automatic settle();
        particle_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_quads.size() != 0);
        repeat (LATENCY) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic run_random_phase(input int count);
        int age;
        int life;
        life = (sb.life_ms == 16'd0) ? 1 : int'(sb.life_ms);
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0:       age = life - 2 + $urandom_range(0, 4);
                1:       age = $urandom_range(0, life);
                default: age = $urandom_range(0, 65535);
            endcase
            if (age < 0)
                age = 0;
            if (age > 65535)
                age = 65535;
            offer_particle(particle_word($urandom_range(0, 1023), age, $urandom,
                                         $urandom, $urandom));
        end
        settle();
    endtask

    initial
    begin
        int phase;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        particle_if.valid <= 1'b0;
        particle_if.data  <= '0;
        rst_n             <= 1'b0;
        hold_request = 1'b0;
        burst_left   = 0;
        settings     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register reset values: field extremes and the lifetime boundary.
        offer_particle(particle_word(0, 0, 0, 0, 256));
        offer_particle(particle_word(1023, 65535, 32767, -32768, 32767));
        offer_particle(particle_word(1, 65535, -32768, 32767, -32768));
        offer_particle(particle_word(2, 999, 256, -256, 256));
        offer_particle(particle_word(3, 1000, -256, 256, 256));
        offer_particle(particle_word(4, 1001, 512, 512, 0));
        offer_particle(particle_word(5, 65535, 100, -100, 0));
        offer_particle(particle_word(6, 1, -1, 1, 128));
        offer_particle(particle_word(7, 30000, 0, 0, -32768));
        offer_particle(particle_word(8, 0, 32767, 32767, 32767));
        offer_particle(particle_word(9, 500, 1, -1, 256));
        settle();

        // Zero lifespan and half-way rounding of the half size.
        set_config(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        offer_particle(particle_word(10, 0, 1, -1, 256));
        offer_particle(particle_word(11, 500, 1, -1, 256));
        offer_particle(particle_word(12, 1, 3, -3, 0));
        offer_particle(particle_word(13, 65535, -32768, 32767, -32768));
        settle();

        set_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        offer_particle(particle_word(14, 65535, 32767, -32768, -32768));
        offer_particle(particle_word(15, 65535, -32768, 32767, 32767));
        offer_particle(particle_word(16, 65534, 0, 0, 0));
        offer_particle(particle_word(17, 1, 32767, 32767, 256));
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
                1: set_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                                    $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                                         : 16'($urandom));
            endcase
            if (phase == 2 || phase == 5)
                hold_request = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        $display("tb_top: %0d quad words checked across %0d register settings",
                 sb.checked, settings);
        $display("tb_top: %0d cycles of input back-pressure, %0d long output hold-offs",
                 input_stalls, holds_done);
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int rx_count;
        int rx_mode;
        rx_count   = 0;
        rx_mode    = 0;
        holds_done = 0;
        forever
        begin
            if (hold_request)
            begin
                quad_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else
            begin
                if (rx_count % 50 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0:       quad_if.ready <= 1'b1;
                    1:       quad_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       quad_if.ready <= ($urandom_range(0, 3) == 0);
                    default: quad_if.ready <= rx_count[2];
                endcase
                rx_count++;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (particle_if.valid && particle_if.ready)
                sb.note_particle(particle_if.data);
            if (particle_if.valid && !particle_if.ready)
                input_stalls++;
            if (quad_if.valid && quad_if.ready)
                sb.check_quad(quad_if.data);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
